>>> design/matrix_line_segment_sum_finder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line segment sum finder
// Shared helpers for concurrent checks; each use expands to one labeled
// assertion clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_LINE_SEGMENT_SUM_FINDER_DEFINES_SVH
`define MATRIX_LINE_SEGMENT_SUM_FINDER_DEFINES_SVH

// same-cycle implication
`define MLSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MLSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mlss_pkg.sv
// ----------------------------------------------------------------------------
// mlss_pkg
// Shared types and constants of the line segment sum finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlss_pkg;

	localparam int MLSS_DIM   = 16;
	localparam int VALUE_W    = 32;
	localparam int BOUND_W    = 4;
	localparam int TOTAL_W    = 13;
	localparam int CFG_SIZE_W = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd2;

	localparam logic [CFG_SIZE_W-1:0] CFG_SIZE_RESET = 5'd16;

	typedef struct packed {
		logic signed [VALUE_W-1:0] target_sum;
		logic [CFG_SIZE_W-1:0]     num_rows;
		logic [CFG_SIZE_W-1:0]     num_cols;
	} cfg_t;

endpackage

`default_nettype wire

>>> design/mlss_ram.sv
// ----------------------------------------------------------------------------
// mlss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/mlss_front.sv
// ----------------------------------------------------------------------------
// mlss_front
// Accepts input items, assigns each its row and column and the total-clear
// flag, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlss_front import mlss_pkg::*; #(
	parameter int DIM = MLSS_DIM,
	localparam int PosW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cfg_t                      cfg,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic                      first,
	output logic                           q_valid,
	input  wire logic                      q_ready,
	output logic signed [VALUE_W-1:0]      q_value,
	output logic [PosW-1:0]                q_row,
	output logic [PosW-1:0]                q_col,
	output logic                           q_clr
);

	localparam int SZW = (($clog2(DIM + 1) > CFG_SIZE_W) ? $clog2(DIM + 1) : CFG_SIZE_W) + 1;
	localparam int QD  = 2;

	logic [PosW-1:0] row_q, col_q;
	logic            end_q;

	logic signed [VALUE_W-1:0] val_mem_q [QD];
	logic [PosW-1:0]           row_mem_q [QD];
	logic [PosW-1:0]           col_mem_q [QD];
	logic                      clr_mem_q [QD];
	logic                      wp_q, rp_q;
	logic [1:0]                cnt_q;

	logic            push, pop;
	logic [PosW-1:0] r_cur, c_cur;
	logic            clr_cur;
	logic [SZW-1:0]  nr_e, nc_e;
	logic            col_wrap, row_wrap;

	function automatic logic [SZW-1:0] eff_size(input logic [CFG_SIZE_W-1:0] n);
		logic [SZW-1:0] res;
		if (n == '0) begin
			res = SZW'(1);
		end else if (SZW'(n) > SZW'(DIM)) begin
			res = SZW'(DIM);
		end else begin
			res = SZW'(n);
		end
		return res;
	endfunction

	assign in_ready = (cnt_q != 2'(QD));
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	assign q_value = val_mem_q[rp_q];
	assign q_row   = row_mem_q[rp_q];
	assign q_col   = col_mem_q[rp_q];
	assign q_clr   = clr_mem_q[rp_q];

	always_comb begin
		r_cur    = first ? '0 : row_q;
		c_cur    = first ? '0 : col_q;
		clr_cur  = first || end_q;
		nr_e     = eff_size(cfg.num_rows);
		nc_e     = eff_size(cfg.num_cols);
		col_wrap = (SZW'(c_cur) + SZW'(1)) >= nc_e;
		row_wrap = (SZW'(r_cur) + SZW'(1)) >= nr_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			end_q <= 1'b0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				if (col_wrap) begin
					col_q <= '0;
					if (row_wrap) begin
						// end of matrix: next item starts a new one
						row_q <= '0;
						end_q <= 1'b1;
					end else begin
						row_q <= r_cur + PosW'(1);
						end_q <= 1'b0;
					end
				end else begin
					col_q <= c_cur + PosW'(1);
					row_q <= r_cur;
					end_q <= 1'b0;
				end
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			val_mem_q[wp_q] <= value;
			row_mem_q[wp_q] <= r_cur;
			col_mem_q[wp_q] <= c_cur;
			clr_mem_q[wp_q] <= clr_cur;
		end
	end

endmodule

`default_nettype wire

>>> design/mlss_back.sv
// ----------------------------------------------------------------------------
// mlss_back
// Updates the row and column prefix memories for one item, then scans the
// earlier prefixes of its row and column and emits every matching run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_line_segment_sum_finder_defines.svh"

module mlss_back import mlss_pkg::*; #(
	parameter int DIM = MLSS_DIM,
	localparam int PosW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cfg_t                      cfg,
	input  wire logic                      q_valid,
	output logic                           q_ready,
	input  wire logic signed [VALUE_W-1:0] q_value,
	input  wire logic [PosW-1:0]           q_row,
	input  wire logic [PosW-1:0]           q_col,
	input  wire logic                      q_clr,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [BOUND_W-1:0]             start_row,
	output logic [BOUND_W-1:0]             start_col,
	output logic [BOUND_W-1:0]             end_row,
	output logic [BOUND_W-1:0]             end_col,
	output logic                           is_column,
	output logic                           last,
	output logic [TOTAL_W-1:0]             total_found
);

	localparam int PW  = VALUE_W + $clog2(DIM) + 1;
	localparam int DW  = PW + 1;
	localparam int CD  = DIM * DIM;
	localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
	localparam logic [CAW:0] DIM_C = (CAW + 1)'(DIM);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_CALC  = 7'b0000100,
		ST_RSCAN = 7'b0001000,
		ST_CSCAN = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t state_q;

	logic signed [VALUE_W-1:0] v_q;
	logic [PosW-1:0]           r_q, c_q, s_q;
	logic signed [PW-1:0]      rp_q, cp_q;
	logic [TOTAL_W-1:0]        total_q;

	logic                      b_vld_s2;
	logic [PosW-1:0]           b_s_s2;
	logic                      b_col_s2;

	logic                      pend_vld_q;
	logic [PosW-1:0]           pend_sr_q, pend_sc_q;
	logic                      pend_col_q;
	logic [TOTAL_W-1:0]        pend_total_q;

	logic                      out_valid_q;
	logic [BOUND_W-1:0]        out_sr_q, out_sc_q, out_er_q, out_ec_q;
	logic                      out_col_q, out_last_q;
	logic [TOTAL_W-1:0]        out_total_q;

	logic                      out_free, stall;
	logic                      issue_row, issue_col;
	logic                      row_re, col_re;
	logic [PosW-1:0]           row_raddr;
	logic [CAW-1:0]            col_raddr;
	logic signed [PW-1:0]      row_rd, col_rd;
	logic                      calc;
	logic signed [PW-1:0]      rp_new, cp_new;
	logic signed [PW-1:0]      base;
	logic signed [DW-1:0]      diff, tgt_ext;
	logic signed [VALUE_W-1:0] tgt;
	logic                      hit;
	logic [TOTAL_W-1:0]        total_inc;
	logic                      push_mid, push_end;

	function automatic logic [CAW-1:0] cell_addr(input logic [PosW-1:0] rr,
		input logic [PosW-1:0] cc);
		logic [CAW:0] a;
		a = (CAW + 1)'(rr) * DIM_C + (CAW + 1)'(cc);
		return a[CAW-1:0];
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign stall     = !out_free;
	assign q_ready   = (state_q == ST_IDLE);
	assign issue_row = (state_q == ST_RSCAN) && !stall;
	assign issue_col = (state_q == ST_CSCAN) && !stall;
	assign calc      = (state_q == ST_CALC);

	always_comb begin
		row_re    = (state_q == ST_LOAD) || issue_row;
		col_re    = (state_q == ST_LOAD) || issue_col;
		row_raddr = (state_q == ST_LOAD) ? (c_q - PosW'(1)) : (s_q - PosW'(1));
		col_raddr = (state_q == ST_LOAD) ? cell_addr(r_q - PosW'(1), c_q)
		                                 : cell_addr(s_q - PosW'(1), c_q);
	end

	// prefixes for the current cell
	always_comb begin
		rp_new = PW'(v_q);
		cp_new = PW'(v_q);
		if (c_q != '0) begin
			rp_new = row_rd + PW'(v_q);
		end
		if (r_q != '0) begin
			cp_new = col_rd + PW'(v_q);
		end
	end

	mlss_ram #(.WIDTH(PW), .DEPTH(DIM)) u_row_ram (
		.clk   (clk),
		.we    (calc),
		.waddr (c_q),
		.wdata (rp_new),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	mlss_ram #(.WIDTH(PW), .DEPTH(CD)) u_col_ram (
		.clk   (clk),
		.we    (calc),
		.waddr (cell_addr(r_q, c_q)),
		.wdata (cp_new),
		.re    (col_re),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	// compare stage: run sum is this prefix minus the one before the start
	always_comb begin
		tgt = cfg.target_sum;
		if (b_s_s2 == '0) begin
			base = '0;
		end else if (b_col_s2) begin
			base = col_rd;
		end else begin
			base = row_rd;
		end
		diff      = (b_col_s2 ? DW'(cp_q) : DW'(rp_q)) - DW'(base);
		tgt_ext   = DW'(tgt);
		hit       = b_vld_s2 && (diff == tgt_ext);
		total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + TOTAL_W'(1);
		push_mid  = hit && !stall && pend_vld_q;
		push_end  = (state_q == ST_FIN) && !stall && pend_vld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			b_vld_s2    <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_clr) begin
							total_q <= '0;
						end
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_RSCAN;
				end
				ST_RSCAN: begin
					if (!stall && s_q == c_q) begin
						state_q <= ST_CSCAN;
					end
				end
				ST_CSCAN: begin
					if (!stall && s_q == r_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stall) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (!stall) begin
				b_vld_s2 <= issue_row || issue_col;
			end
			if (hit && !stall) begin
				total_q    <= total_inc;
				pend_vld_q <= 1'b1;
			end else if (push_end) begin
				pend_vld_q <= 1'b0;
			end

			if (push_mid || push_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			v_q <= q_value;
			r_q <= q_row;
			c_q <= q_col;
		end
		if (calc) begin
			rp_q <= rp_new;
			cp_q <= cp_new;
			s_q  <= '0;
		end
		if (issue_row || issue_col) begin
			b_s_s2   <= s_q;
			b_col_s2 <= issue_col;
			// restart the index for the column scan
			s_q      <= (issue_row && s_q == c_q) ? '0 : s_q + PosW'(1);
		end
		if (hit && !stall) begin
			pend_sr_q    <= b_col_s2 ? b_s_s2 : r_q;
			pend_sc_q    <= b_col_s2 ? c_q : b_s_s2;
			pend_col_q   <= b_col_s2;
			pend_total_q <= total_inc;
		end
		if (push_mid || push_end) begin
			out_sr_q    <= BOUND_W'(pend_sr_q);
			out_sc_q    <= BOUND_W'(pend_sc_q);
			out_er_q    <= BOUND_W'(r_q);
			out_ec_q    <= BOUND_W'(c_q);
			out_col_q   <= pend_col_q;
			out_last_q  <= push_end;
			out_total_q <= pend_total_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign start_row   = out_sr_q;
	assign start_col   = out_sc_q;
	assign end_row     = out_er_q;
	assign end_col     = out_ec_q;
	assign is_column   = out_col_q;
	assign last        = out_last_q;
	assign total_found = out_total_q;

	`MLSS_ASSERT_IMP(a_idle_empty, clk, arst_n, (state_q == ST_IDLE),
		(!pend_vld_q && !b_vld_s2), "pending match or compare left over at item start")
	`MLSS_ASSERT_IMP(a_rscan_bound, clk, arst_n, (state_q == ST_RSCAN),
		(s_q <= c_q), "row scan index past end column")
	`MLSS_ASSERT_IMP(a_cscan_bound, clk, arst_n, (state_q == ST_CSCAN),
		(s_q <= r_q), "column scan index past end row")
	`MLSS_ASSERT_IMP(a_cmp_in_scan, clk, arst_n, b_vld_s2,
		(state_q == ST_RSCAN || state_q == ST_CSCAN || state_q == ST_DRAIN),
		"compare stage busy outside a scan")
	`MLSS_ASSERT_NXT(a_fin_last, clk, arst_n, push_end,
		(out_valid_q && out_last_q && !pend_vld_q), "final match not marked last")

endmodule

`default_nettype wire

>>> design/matrix_line_segment_sum_finder.sv
// Output: each match of an element is held until the next one is found, and the
//   last one leaves marked last once both scans of that element finish.
// Elements: the back end takes a new element only after finishing the last one,
//   scanning its row and column prefix memories, one prefix read per cycle unless the output stalls.
// Reset: arst_n clears position, match total, queue and handshake state; prefix
//   memories are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// matrix_line_segment_sum_finder
// Streams a matrix in raster order and reports every horizontal and vertical
// run ending at each element whose sum equals the target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_line_segment_sum_finder import mlss_pkg::*; #(
	parameter int DIM = MLSS_DIM
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [VALUE_W-1:0]          cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [VALUE_W-1:0]   value,
	input  wire logic                        first,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [BOUND_W-1:0]               start_row,
	output logic [BOUND_W-1:0]               start_col,
	output logic [BOUND_W-1:0]               end_row,
	output logic [BOUND_W-1:0]               end_col,
	output logic                             is_column,
	output logic                             last,
	output logic [TOTAL_W-1:0]               total_found
);

	localparam int PosW = (DIM > 1) ? $clog2(DIM) : 1;

	cfg_t cfg_q;

	logic                      q_valid, q_ready, q_clr;
	logic signed [VALUE_W-1:0] q_value;
	logic [PosW-1:0]           q_row, q_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_sum <= '0;
			cfg_q.num_rows   <= CFG_SIZE_RESET;
			cfg_q.num_cols   <= CFG_SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TARGET_SUM: cfg_q.target_sum <= cfg_data;
				REG_NUM_ROWS:   cfg_q.num_rows   <= cfg_data[CFG_SIZE_W-1:0];
				REG_NUM_COLS:   cfg_q.num_cols   <= cfg_data[CFG_SIZE_W-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	mlss_front #(.DIM(DIM)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.first    (first),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_value  (q_value),
		.q_row    (q_row),
		.q_col    (q_col),
		.q_clr    (q_clr)
	);

	mlss_back #(.DIM(DIM)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_value     (q_value),
		.q_row       (q_row),
		.q_col       (q_col),
		.q_clr       (q_clr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.start_row   (start_row),
		.start_col   (start_col),
		.end_row     (end_row),
		.end_col     (end_col),
		.is_column   (is_column),
		.last        (last),
		.total_found (total_found)
	);

endmodule

`default_nettype wire
